/* rtl/colaff_pkg.sv */
package colaff_pkg;

    localparam int ADDR_W      = 16;
    localparam int STORE_DEPTH = 65536;
    localparam int LUMA_W      = 8;
    localparam int DIM_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COEF_W      = 32;
    localparam int RHS_W       = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_GAIN  = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_ROW  = 1'b1;

    localparam logic [DIM_W-1:0] DIM_MAX  = 9'd256;
    localparam logic [7:0]       WIN_HALF = 8'd2;

    localparam logic [24:0] VAR_FLOOR     = 25'd33;
    localparam logic [41:0] WEIGHT_OFFSET = 42'd3277;
    localparam logic [35:0] COEF_MAX      = 36'h07FFFFFFF;

    localparam int DIV_NUM_W = 41;
    localparam int DIV_DEN_W = 25;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
        logic [DIV_DEN_W-1:0] rem;
    } t_div_rsp;

    // Lower window bound, clipped at zero.
    function automatic logic [7:0] win_lo(input logic [7:0] v, input logic [7:0] half);
        win_lo = (v >= half) ? 8'(v - half) : 8'd0;
    endfunction

    // Upper window bound, clipped at lim.
    function automatic logic [7:0] win_hi(input logic [7:0] v, input logic [7:0] half,
                                          input logic [7:0] lim);
        logic [8:0] s;
        s = {1'b0, v} + {1'b0, half};
        win_hi = (s > {1'b0, lim}) ? lim : s[7:0];
    endfunction

    // round(lam * mark / 256), rounding half up.
    function automatic logic [RHS_W-1:0] rhs_of(input logic [15:0] lam,
                                                input logic signed [15:0] mark);
        logic signed [32:0] p;
        logic signed [32:0] r;
        p = $signed({1'b0, lam}) * mark;
        r = (p + 33'sd128) >>> 8;
        rhs_of = r[RHS_W-1:0];
    endfunction

endpackage

/* rtl/colaff_div.sv */
module colaff_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  colaff_pkg::t_div_req i_req,
    output colaff_pkg::t_div_rsp o_rsp
);
    import colaff_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W:0]   c_trial;
    logic                 c_fit;

    assign c_trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign c_fit   = (c_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle, restoring.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], c_fit};
            r_rem <= c_fit ? DIV_DEN_W'(c_trial - {1'b0, r_den}) : c_trial[DIV_DEN_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
    assign o_rsp.rem  = r_rem;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without run");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != DIV_CNT_W'(1) |=> r_busy) else $error("divider stopped early");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("divider count underflow");

endmodule

/* rtl/colorization_affinity_rows.sv */
// Load request: written to the store when accepted, busy stays low.
// Compute request: window statistics (n up to 25 samples), then one division per neighbor;
// the run time is set by the shared one-bit-per-cycle divider
// (41 steps per division, up to eleven divisions).
// Each result holds the output ports for one cycle under o_valid; the receiver cannot stall it.
// Reset is synchronous active low; registers return to 256, 256, 256; the store is not cleared.
module colorization_affinity_rows (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    output logic                                     o_busy,
    input  logic                                     i_mode,
    input  logic [colaff_pkg::ADDR_W-1:0]            i_pixel_index,
    input  logic [colaff_pkg::LUMA_W-1:0]            i_luma,
    input  logic                                     i_marked,
    input  logic signed [15:0]                       i_mark_u,
    input  logic signed [15:0]                       i_mark_v,
    input  logic                                     i_cfg_we,
    input  logic [colaff_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [colaff_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                     o_valid,
    output logic [colaff_pkg::ADDR_W-1:0]            o_row_index,
    output logic [colaff_pkg::ADDR_W-1:0]            o_col_index,
    output logic signed [colaff_pkg::COEF_W-1:0]     o_coef,
    output logic signed [colaff_pkg::RHS_W-1:0]      o_rhs_u,
    output logic signed [colaff_pkg::RHS_W-1:0]      o_rhs_v,
    output logic                                     o_last
);
    import colaff_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DIVXY, S_SUM, S_SUMW, S_DIVMEAN, S_SQ, S_SQW, S_DIVVAR,
        S_CREAD, S_CWAIT, S_NREAD, S_NWAIT, S_NMUL, S_NDIV, S_RHSU, S_DIAG
    } t_state;

    t_state r_state;

    logic [DIM_W-1:0]  r_width, r_height;
    logic [15:0]       r_lambda;

    logic [LUMA_W-1:0] r_mem [0:STORE_DEPTH-1];
    logic [LUMA_W-1:0] r_rd_data;

    logic [ADDR_W-1:0] r_idx;
    logic              r_marked;
    logic signed [15:0] r_mark_u, r_mark_v;
    logic [7:0]        r_x, r_y, r_x0, r_x1, r_y0, r_y1, r_k, r_z;
    logic              r_v1, r_v2, r_pass2;
    logic [12:0]       r_sum;
    logic [4:0]        r_n;
    logic [31:0]       r_sq;
    logic [36:0]       r_sumsq;
    logic [15:0]       r_mean;
    logic [24:0]       r_var;
    logic signed [16:0] r_dc;
    logic signed [33:0] r_prod;
    logic [35:0]       r_total;
    logic [RHS_W-1:0]  r_rhs_u;
    t_div_req          r_div_req;
    t_div_rsp          c_div_rsp;

    logic [DIM_W-1:0]  c_w, c_h;
    logic [7:0]        c_wm1, c_hm1;
    logic [16:0]       c_row_base;
    logic [ADDR_W-1:0] c_scan_addr, c_addr;
    logic              c_scan_last, c_accept;
    logic [7:0]        c_dx, c_dy;
    logic signed [16:0] c_d;
    logic signed [33:0] c_dsq;
    logic [31:0]       c_abs_prod;
    logic [41:0]       c_q, c_wt;
    logic [35:0]       c_wt_sat, c_diag, c_diag_sat;

    assign c_w   = (r_width == '0) ? DIM_W'(1) : ((r_width > DIM_MAX) ? DIM_MAX : r_width);
    assign c_h   = (r_height == '0) ? DIM_W'(1) : ((r_height > DIM_MAX) ? DIM_MAX : r_height);
    assign c_wm1 = 8'(c_w - 1'b1);
    assign c_hm1 = 8'(c_h - 1'b1);

    assign c_row_base  = r_z * c_w;
    assign c_scan_addr = ADDR_W'(c_row_base + {9'd0, r_k});
    assign c_addr      = (r_state == S_CREAD) ? r_idx : c_scan_addr;
    assign c_scan_last = (r_k == r_x1) && (r_z == r_y1);
    assign c_accept    = i_start && !o_busy;
    assign o_busy      = (r_state != S_IDLE);

    assign c_dx = c_div_rsp.rem[7:0];
    assign c_dy = c_div_rsp.quot[7:0];

    assign c_d   = $signed({1'b0, r_rd_data, 8'd0}) - $signed({1'b0, r_mean});
    assign c_dsq = c_d * c_d;

    assign c_abs_prod = r_prod[33] ? 32'(-r_prod) : r_prod[31:0];
    assign c_q        = {1'b0, c_div_rsp.quot};
    assign c_wt       = !r_prod[33] ? c_q + WEIGHT_OFFSET :
                        ((c_q > WEIGHT_OFFSET) ? c_q - WEIGHT_OFFSET : WEIGHT_OFFSET - c_q);
    assign c_wt_sat   = (c_wt > {6'd0, COEF_MAX}) ? COEF_MAX : c_wt[35:0];
    assign c_diag     = r_total + (r_marked ? {12'd0, r_lambda, 8'd0} : 36'd0);
    assign c_diag_sat = (c_diag > COEF_MAX) ? COEF_MAX : c_diag;

    colaff_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (c_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (c_accept && i_mode == MODE_LOAD) begin
            r_mem[i_pixel_index] <= i_luma;
        end
        r_rd_data <= r_mem[c_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_width         <= DIM_MAX;
            r_height        <= DIM_MAX;
            r_lambda        <= 16'd256;
            r_v1            <= 1'b0;
            r_v2            <= 1'b0;
            r_pass2         <= 1'b0;
            r_div_req.start <= 1'b0;
            o_valid         <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            o_valid         <= 1'b0;
            r_v1            <= 1'b0;
            r_v2            <= r_v1;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                    REG_FRAME_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                    REG_LAMBDA_GAIN:  r_lambda <= i_cfg_data;
                    default: ;
                endcase
            end

            // Window statistics pipeline: read, then sum (pass 1) or square and sum (pass 2).
            if (r_v1 && !r_pass2) begin
                r_sum <= r_sum + 13'(r_rd_data);
                r_n   <= r_n + 1'b1;
            end
            r_sq <= c_dsq[31:0];
            if (r_v2 && r_pass2) begin
                r_sumsq <= r_sumsq + 37'(r_sq);
            end

            case (r_state)
                S_IDLE: begin
                    if (c_accept && i_mode == MODE_ROW) begin
                        r_idx           <= i_pixel_index;
                        r_marked        <= i_marked;
                        r_mark_u        <= i_mark_u;
                        r_mark_v        <= i_mark_v;
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= DIV_NUM_W'(i_pixel_index);
                        r_div_req.den   <= DIV_DEN_W'(c_w);
                        r_state         <= S_DIVXY;
                    end
                end
                S_DIVXY: begin
                    if (c_div_rsp.done) begin
                        if (c_div_rsp.quot >= DIV_NUM_W'(c_h)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_x     <= c_dx;
                            r_y     <= c_dy;
                            r_x0    <= win_lo(c_dx, WIN_HALF);
                            r_x1    <= win_hi(c_dx, WIN_HALF, c_wm1);
                            r_y0    <= win_lo(c_dy, WIN_HALF);
                            r_y1    <= win_hi(c_dy, WIN_HALF, c_hm1);
                            r_k     <= win_lo(c_dx, WIN_HALF);
                            r_z     <= win_lo(c_dy, WIN_HALF);
                            r_sum   <= '0;
                            r_n     <= '0;
                            r_pass2 <= 1'b0;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM, S_SQ: begin
                    r_v1 <= 1'b1;
                    if (c_scan_last) begin
                        r_state <= (r_state == S_SUM) ? S_SUMW : S_SQW;
                    end else if (r_z == r_y1) begin
                        r_z <= r_y0;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_z <= r_z + 1'b1;
                    end
                end
                S_SUMW: begin
                    if (!r_v1 && !r_v2) begin
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= DIV_NUM_W'({r_sum, 8'd0}) + DIV_NUM_W'(r_n >> 1);
                        r_div_req.den   <= DIV_DEN_W'(r_n);
                        r_state         <= S_DIVMEAN;
                    end
                end
                S_DIVMEAN: begin
                    if (c_div_rsp.done) begin
                        r_mean  <= c_div_rsp.quot[15:0];
                        r_k     <= r_x0;
                        r_z     <= r_y0;
                        r_sumsq <= '0;
                        r_pass2 <= 1'b1;
                        r_state <= S_SQ;
                    end
                end
                S_SQW: begin
                    if (!r_v1 && !r_v2) begin
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= DIV_NUM_W'(r_sumsq) + DIV_NUM_W'({r_n, 7'd0});
                        r_div_req.den   <= DIV_DEN_W'({r_n, 8'd0});
                        r_state         <= S_DIVVAR;
                    end
                end
                S_DIVVAR: begin
                    if (c_div_rsp.done) begin
                        r_var   <= (c_div_rsp.quot < DIV_NUM_W'(VAR_FLOOR)) ?
                                   VAR_FLOOR : c_div_rsp.quot[24:0];
                        r_state <= S_CREAD;
                    end
                end
                S_CREAD: begin
                    r_state <= S_CWAIT;
                end
                S_CWAIT: begin
                    r_dc    <= c_d;
                    r_x0    <= win_lo(r_x, 8'd1);
                    r_x1    <= win_hi(r_x, 8'd1, c_wm1);
                    r_y0    <= win_lo(r_y, 8'd1);
                    r_y1    <= win_hi(r_y, 8'd1, c_hm1);
                    r_k     <= win_lo(r_x, 8'd1);
                    r_z     <= win_lo(r_y, 8'd1);
                    r_total <= '0;
                    r_state <= S_NREAD;
                end
                S_NREAD: begin
                    // Skip the center pixel itself.
                    if (r_k == r_x && r_z == r_y) begin
                        if (c_scan_last) begin
                            r_state <= S_RHSU;
                        end else if (r_z == r_y1) begin
                            r_z <= r_y0;
                            r_k <= r_k + 1'b1;
                        end else begin
                            r_z <= r_z + 1'b1;
                        end
                    end else begin
                        r_state <= S_NWAIT;
                    end
                end
                S_NWAIT: begin
                    r_prod  <= r_dc * c_d;
                    r_state <= S_NMUL;
                end
                S_NMUL: begin
                    r_div_req.start <= 1'b1;
                    r_div_req.num   <= DIV_NUM_W'({c_abs_prod, 8'd0}) + DIV_NUM_W'(r_var >> 1);
                    r_div_req.den   <= r_var;
                    r_state         <= S_NDIV;
                end
                S_NDIV: begin
                    if (c_div_rsp.done) begin
                        o_valid     <= 1'b1;
                        o_row_index <= r_idx;
                        o_col_index <= c_scan_addr;
                        o_coef      <= COEF_W'(-$signed({1'b0, c_wt_sat[30:0]}));
                        o_rhs_u     <= '0;
                        o_rhs_v     <= '0;
                        o_last      <= 1'b0;
                        r_total     <= r_total + c_wt_sat;
                        if (c_scan_last) begin
                            r_state <= S_RHSU;
                        end else begin
                            r_state <= S_NREAD;
                            if (r_z == r_y1) begin
                                r_z <= r_y0;
                                r_k <= r_k + 1'b1;
                            end else begin
                                r_z <= r_z + 1'b1;
                            end
                        end
                    end
                end
                S_RHSU: begin
                    r_rhs_u <= r_marked ? rhs_of(r_lambda, r_mark_u) : '0;
                    r_state <= S_DIAG;
                end
                S_DIAG: begin
                    o_valid     <= 1'b1;
                    o_row_index <= r_idx;
                    o_col_index <= r_idx;
                    o_coef      <= c_diag_sat[COEF_W-1:0];
                    o_rhs_u     <= r_rhs_u;
                    o_rhs_v     <= r_marked ? rhs_of(r_lambda, r_mark_v) : '0;
                    o_last      <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !o_busy) else $error("busy after row end");
    a_neighbor_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> (o_coef[31] || o_coef == '0)) else $error("positive off-diagonal");
    a_neighbor_rhs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> (o_rhs_u == '0 && o_rhs_v == '0))
        else $error("rhs on off-diagonal");
    a_div_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_div_rsp.done |-> o_busy) else $error("divider result while idle");
    a_diag_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_col_index == o_row_index) else $error("diagonal column mismatch");

endmodule

/* verif/colorization_affinity_rows_tb.sv */
`timescale 1ns / 1ps

module colorization_affinity_rows_tb;
    import colaff_pkg::*;

    localparam int   SETTLE    = 600;
    localparam int   STALL_MAX = 5000;

    typedef enum int {LUMA_RANDOM, LUMA_FLAT, LUMA_EXTREME} luma_fill_e;

    typedef struct {
        logic [15:0] row;
        logic [15:0] col;
        logic [31:0] coef;
        logic [23:0] rhs_u;
        logic [23:0] rhs_v;
        logic        last;
    } matrix_entry_t;

    class affinity_scoreboard;
        bit [7:0]      luma_mem [65536];
        logic [15:0]   width_reg;
        logic [15:0]   height_reg;
        logic [15:0]   lambda_reg;
        matrix_entry_t pending_entries [$];
        int            fails;

        function new();
            width_reg  = 256;
            height_reg = 256;
            lambda_reg = 256;
            fails      = 0;
        endfunction

        function int unsigned dim(input logic [15:0] r);
            int unsigned v;
            v = r[8:0];
            if (v < 1) v = 1;
            if (v > 256) v = 256;
            return v;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = data;
                REG_FRAME_HEIGHT: height_reg = data;
                REG_LAMBDA_GAIN:  lambda_reg = data;
                default: ;
            endcase
        endfunction

        function void push_entry(input logic [15:0] row, input logic [15:0] col,
                                 input longint coef, input longint ru, input longint rv,
                                 input logic last);
            matrix_entry_t e;
            e.row   = row;
            e.col   = col;
            e.coef  = coef[31:0];
            e.rhs_u = ru[23:0];
            e.rhs_v = rv[23:0];
            e.last  = last;
            pending_entries.push_back(e);
        endfunction

        // Predict the row for one accepted row request, or record the sample of a load.
        function void note_request(input logic mode, input logic [15:0] idx,
                                   input logic [7:0] luma, input logic mk,
                                   input logic signed [15:0] mu,
                                   input logic signed [15:0] mv);
            int unsigned w, h, x, y, x0, x1, y0, y1, n, col;
            longint sum, mean, dc, prod, mag, q, t, wt, total, lam, ru, rv;
            longint unsigned sumsq, var_q;
            if (mode == MODE_LOAD) begin
                luma_mem[idx] = luma;
                return;
            end
            w = dim(width_reg);
            h = dim(height_reg);
            x = idx % w;
            y = idx / w;
            if (y >= h) return;
            x0 = (x >= 2) ? x - 2 : 0;
            y0 = (y >= 2) ? y - 2 : 0;
            x1 = (x + 2 > w - 1) ? w - 1 : x + 2;
            y1 = (y + 2 > h - 1) ? h - 1 : y + 2;
            sum = 0;
            n = 0;
            for (int unsigned k = x0; k <= x1; k++)
                for (int unsigned z = y0; z <= y1; z++) begin
                    sum += longint'(luma_mem[z * w + k]);
                    n++;
                end
            mean = (sum * 256 + longint'(n / 2)) / longint'(n);
            sumsq = 0;
            for (int unsigned k = x0; k <= x1; k++)
                for (int unsigned z = y0; z <= y1; z++) begin
                    dc = longint'(luma_mem[z * w + k]) * 256 - mean;
                    sumsq += longint'(dc * dc);
                end
            var_q = (sumsq + n * 128) / (n * 256);
            if (var_q < 33) var_q = 33;
            dc = longint'(luma_mem[idx]) * 256 - mean;
            x0 = (x >= 1) ? x - 1 : 0;
            y0 = (y >= 1) ? y - 1 : 0;
            x1 = (x + 1 > w - 1) ? w - 1 : x + 1;
            y1 = (y + 1 > h - 1) ? h - 1 : y + 1;
            total = 0;
            for (int unsigned k = x0; k <= x1; k++)
                for (int unsigned z = y0; z <= y1; z++) begin
                    if (k == x && z == y) continue;
                    col  = z * w + k;
                    prod = dc * (longint'(luma_mem[col]) * 256 - mean);
                    mag  = ((prod < 0) ? -prod : prod) * 256 + longint'(var_q / 2);
                    q    = mag / longint'(var_q);
                    t    = 3277 + ((prod < 0) ? -q : q);
                    wt   = (t < 0) ? -t : t;
                    if (wt > 64'sd2147483647) wt = 64'sd2147483647;
                    total += wt;
                    push_entry(idx, col[15:0], -wt, 0, 0, 1'b0);
                end
            ru = 0;
            rv = 0;
            if (mk) begin
                lam = longint'(lambda_reg);
                total += lam * 256;
                ru = (lam * longint'(mu) + 128) >>> 8;
                rv = (lam * longint'(mv) + 128) >>> 8;
            end
            if (total > 64'sd2147483647) total = 64'sd2147483647;
            push_entry(idx, idx, total, ru, rv, 1'b1);
        endfunction

        function void check_entry(input matrix_entry_t got);
            matrix_entry_t exp_e;
            if (pending_entries.size() == 0) begin
                $error("unexpected entry row=%0d col=%0d", got.row, got.col);
                fails++;
                return;
            end
            exp_e = pending_entries.pop_front();
            if (got.row !== exp_e.row) begin
                $error("row_index: expected %0d actual %0d", exp_e.row, got.row);
                fails++;
            end
            if (got.col !== exp_e.col) begin
                $error("col_index: expected %0d actual %0d", exp_e.col, got.col);
                fails++;
            end
            if (got.coef !== exp_e.coef) begin
                $error("coef: expected %0d actual %0d",
                       $signed(exp_e.coef), $signed(got.coef));
                fails++;
            end
            if (got.rhs_u !== exp_e.rhs_u) begin
                $error("rhs_u: expected %0d actual %0d",
                       $signed(exp_e.rhs_u), $signed(got.rhs_u));
                fails++;
            end
            if (got.rhs_v !== exp_e.rhs_v) begin
                $error("rhs_v: expected %0d actual %0d",
                       $signed(exp_e.rhs_v), $signed(got.rhs_v));
                fails++;
            end
            if (got.last !== exp_e.last) begin
                $error("last: expected %0d actual %0d", exp_e.last, got.last);
                fails++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic                  i_mode;
    logic [ADDR_W-1:0]     i_pixel_index;
    logic [LUMA_W-1:0]     i_luma;
    logic                  i_marked;
    logic signed [15:0]    i_mark_u;
    logic signed [15:0]    i_mark_v;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_valid;
    logic [ADDR_W-1:0]     o_row_index;
    logic [ADDR_W-1:0]     o_col_index;
    logic signed [COEF_W-1:0] o_coef;
    logic signed [RHS_W-1:0]  o_rhs_u;
    logic signed [RHS_W-1:0]  o_rhs_v;
    logic                  o_last;

    affinity_scoreboard sb = new();
    bit                 luma_written [65536];
    int                 idle_cycles = 0;

    colorization_affinity_rows uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_mode(i_mode), .i_pixel_index(i_pixel_index), .i_luma(i_luma),
        .i_marked(i_marked), .i_mark_u(i_mark_u), .i_mark_v(i_mark_v),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_row_index(o_row_index), .o_col_index(o_col_index),
        .o_coef(o_coef), .o_rhs_u(o_rhs_u), .o_rhs_v(o_rhs_v), .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        matrix_entry_t got;
        if (i_rst_n && o_valid) begin
            got.row   = o_row_index;
            got.col   = o_col_index;
            got.coef  = o_coef;
            got.rhs_u = o_rhs_u;
            got.rhs_v = o_rhs_v;
            got.last  = o_last;
            sb.check_entry(got);
        end
    end

    // Hang detection: count cycles in which no request and no entry moves.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic mode, input logic [15:0] idx,
                                input logic [7:0] luma, input logic mk,
                                input logic signed [15:0] mu,
                                input logic signed [15:0] mv);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_mode        <= mode;
        i_pixel_index <= idx;
        i_luma        <= luma;
        i_marked      <= mk;
        i_mark_u      <= mu;
        i_mark_v      <= mv;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        sb.note_request(mode, idx, luma, mk, mu, mv);
        if (mode == MODE_LOAD) luma_written[idx] = 1'b1;
    endtask

    function automatic logic [7:0] pick_luma(input luma_fill_e fill);
        case (fill)
            LUMA_FLAT:    return 8'd128;
            LUMA_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            default:      return 8'($urandom);
        endcase
    endfunction

    // Load any unwritten sample of the statistics window, then request the row.
    task automatic request_row(input logic [15:0] idx, input luma_fill_e fill,
                               input logic mk, input logic signed [15:0] mu,
                               input logic signed [15:0] mv);
        int unsigned w, h, x, y, col;
        w = sb.dim(sb.width_reg);
        h = sb.dim(sb.height_reg);
        x = idx % w;
        y = idx / w;
        if (y < h) begin
            for (int unsigned k = (x >= 2 ? x - 2 : 0); k <= x + 2 && k < w; k++)
                for (int unsigned z = (y >= 2 ? y - 2 : 0); z <= y + 2 && z < h; z++) begin
                    col = z * w + k;
                    if (!luma_written[col])
                        send_request(MODE_LOAD, col[15:0], pick_luma(fill), 1'($urandom),
                                     16'($urandom), 16'($urandom));
                end
        end
        send_request(MODE_ROW, idx, 8'($urandom), mk, mu, mv);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sb.pending_entries.size() == 0) break;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input int rows);
        int unsigned w, h, span;
        logic [15:0] idx;
        w = sb.dim(sb.width_reg);
        h = sb.dim(sb.height_reg);
        span = w * h;
        for (int i = 0; i < rows; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                idx = 16'($urandom_range(0, span - 1));
                send_request(MODE_LOAD, idx, pick_luma(luma_fill_e'($urandom_range(0, 2))),
                             1'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                if ($urandom_range(0, 9) == 0)
                    idx = 16'($urandom);
                else
                    idx = 16'($urandom_range(0, span - 1));
                request_row(idx, luma_fill_e'($urandom_range(0, 2)), 1'($urandom),
                            16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_mode        = MODE_LOAD;
        i_pixel_index = '0;
        i_luma        = '0;
        i_marked      = 1'b0;
        i_mark_u      = '0;
        i_mark_v      = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_FRAME_WIDTH;
        i_cfg_data    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: corners, a flat window and an interior pixel.
        request_row(16'd0, LUMA_EXTREME, 1'b1, -16'sd32768, 16'sd32767);
        request_row(16'd65535, LUMA_FLAT, 1'b0, 16'sd0, 16'sd0);
        request_row(16'd257, LUMA_RANDOM, 1'b1, 16'sd32767, -16'sd32768);
        request_row(16'd255, LUMA_EXTREME, 1'b1, 16'sd1, -16'sd1);
        drain();

        // Zero width counts as one; upper data bits are dropped.
        write_reg(REG_FRAME_WIDTH, 16'd0);
        write_reg(REG_FRAME_HEIGHT, 16'hFE03);
        write_reg(REG_LAMBDA_GAIN, 16'hFFFF);
        request_row(16'd0, LUMA_EXTREME, 1'b1, -16'sd32768, -16'sd32768);
        request_row(16'd1, LUMA_EXTREME, 1'b1, 16'sd32767, 16'sd32767);
        request_row(16'd2, LUMA_EXTREME, 1'b0, 16'sd32767, 16'sd32767);
        request_row(16'd3, LUMA_RANDOM, 1'b1, 16'sd5, 16'sd5);
        drain();

        // Oversized width clamps to the maximum; zero lambda.
        write_reg(REG_FRAME_WIDTH, 16'h01FF);
        write_reg(REG_FRAME_HEIGHT, 16'd1);
        write_reg(REG_LAMBDA_GAIN, 16'd0);
        request_row(16'd0, LUMA_RANDOM, 1'b1, 16'sd1234, -16'sd1234);
        request_row(16'd255, LUMA_FLAT, 1'b1, -16'sd1, 16'sd1);
        request_row(16'd256, LUMA_RANDOM, 1'b1, 16'sd7, 16'sd7);
        drain();

        for (int p = 0; p < 4; p++) begin
            write_reg(REG_FRAME_WIDTH, 16'($urandom_range(0, 6)));
            write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(1, 6)));
            write_reg(REG_LAMBDA_GAIN, 16'($urandom));
            random_phase(18);
            drain();
        end

        write_reg(REG_FRAME_WIDTH, 16'd256);
        write_reg(REG_FRAME_HEIGHT, 16'd256);
        write_reg(REG_LAMBDA_GAIN, 16'($urandom));
        random_phase(1);
        drain();

        if (sb.fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
